>>> src/ptm_pkg.sv
// Shared types and constants for the packed triangular matrix-vector block.
package ptm_pkg;

    localparam int MAX_N_DEF   = 64;
    localparam int CMDQ_DEPTH  = 4;
    localparam int RESQ_DEPTH  = 2;
    localparam int CFG_ADDR_W  = 4;
    localparam int ORDER_RESET = 8;

    typedef enum logic [1:0] {
        OP_LOAD_MAT = 2'd0,
        OP_LOAD_VEC = 2'd1,
        OP_START    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_TRANS = 2'd1,
        REG_UNIT  = 2'd2,
        REG_ORDER = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_ROW   = 2'd1,
        S_DRAIN = 2'd2,
        S_EMIT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         result_index;
        logic               last;
    } t_result;

    typedef struct packed {
        logic       lower_triangle;
        logic       transposed_layout;
        logic       unit_diagonal;
        logic [6:0] order;
    } t_cfg;

    // Queue status between two modules
    typedef struct packed {
        logic avail;
    } t_qctl;

endpackage

>>> src/ptm_front.sv
// Front end: accepts items, drops unused opcodes, queues commands for the engine.
module ptm_front
    import ptm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_take,
    output t_qctl o_ctl,
    output t_item o_cmd
);
    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_item             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_acc, w_keep, w_pop;

    assign o_full = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign w_acc  = i_push && !o_full;
    // keep only real commands
    assign w_keep = w_acc && (t_op'(i_item.opcode) != OP_NONE);
    assign w_pop  = i_take && (r_cnt != '0);

    assign o_ctl.avail = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_keep) begin
                r_wr <= (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_keep) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

>>> src/ptm_engine.sv
// Back end: stores matrix and vector, runs one multiply-accumulate per cycle while a row is issuing.
module ptm_engine
    import ptm_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_qctl   i_cmd_ctl,
    input  t_item   i_cmd,
    output logic    o_cmd_take,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);
    localparam int DEPTH  = MAX_N * (MAX_N + 1) / 2;
    localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NCNT_W = $clog2(MAX_N + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MCNT_W = $clog2(DEPTH + 1);
    localparam int AW     = ADDR_W + 1;
    localparam int ACC_W  = 64 + IDX_W + 1;

    logic signed [31:0] r_pmem [DEPTH];
    logic signed [31:0] r_vmem [MAX_N];

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_row, r_col;
    logic [NCNT_W-1:0]   r_n;
    logic [MCNT_W-1:0]   r_mcnt;
    logic [NCNT_W-1:0]   r_vcnt;
    logic                r_s1_valid, r_s1_last, r_s1_unit;
    logic signed [31:0]  r_t, r_x;
    logic                r_s2_valid, r_s2_last;
    logic signed [63:0]  r_p;
    logic signed [ACC_W-1:0] r_acc;

    logic [IDX_W-1:0]  w_hi, w_nm1;
    logic [NCNT_W-1:0] w_n;
    logic              w_issue, w_issue_last, w_emit, w_start, w_lmat, w_lvec;
    logic [AW-1:0]     w_r, w_c, w_nn, w_tri_r, w_tri_c, w_addr;
    logic signed [31:0] w_sat;

    assign w_nm1 = IDX_W'(r_n - 1'b1);
    assign w_hi  = i_cfg.lower_triangle ? r_row : w_nm1;

    // clamp the order into 1..MAX_N
    always_comb begin
        if (i_cfg.order == '0) begin
            w_n = NCNT_W'(1);
        end else if (i_cfg.order > 7'(MAX_N)) begin
            w_n = NCNT_W'(MAX_N);
        end else begin
            w_n = NCNT_W'(i_cfg.order);
        end
    end

    // packed position of (row, col)
    assign w_r     = AW'(r_row);
    assign w_c     = AW'(r_col);
    assign w_nn    = AW'(r_n);
    assign w_tri_r = AW'((w_r * (w_r + 1'b1)) >> 1);
    assign w_tri_c = AW'((w_c * (w_c + 1'b1)) >> 1);
    always_comb begin
        unique case ({i_cfg.lower_triangle, i_cfg.transposed_layout})
            2'b00:   w_addr = w_tri_c + w_r;
            2'b01:   w_addr = AW'(w_r * w_nn) - w_tri_r + w_c;
            2'b10:   w_addr = AW'(w_c * w_nn) - w_tri_c + w_r;
            default: w_addr = w_tri_r + w_c;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_ctl.avail && t_op'(i_cmd.opcode) == OP_START) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (r_col == w_hi) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_s2_valid && r_s2_last) begin
                    n_state = S_EMIT;
                end
            end
            default: begin
                if (!i_res_full) begin
                    n_state = (r_row == w_nm1) ? S_IDLE : S_ROW;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_take   = 1'b0;
        w_start      = 1'b0;
        w_lmat       = 1'b0;
        w_lvec       = 1'b0;
        w_issue      = 1'b0;
        w_issue_last = 1'b0;
        w_emit       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_take = i_cmd_ctl.avail;
                w_start = i_cmd_ctl.avail && t_op'(i_cmd.opcode) == OP_START;
                w_lmat  = i_cmd_ctl.avail && t_op'(i_cmd.opcode) == OP_LOAD_MAT;
                w_lvec  = i_cmd_ctl.avail && t_op'(i_cmd.opcode) == OP_LOAD_VEC;
            end
            S_ROW: begin
                w_issue      = 1'b1;
                w_issue_last = (r_col == w_hi);
            end
            S_DRAIN: ;
            default: w_emit = !i_res_full;
        endcase
    end

    // saturate floor(acc / 2^16)
    always_comb begin
        if (&r_acc[ACC_W-1:47] || ~|r_acc[ACC_W-1:47]) begin
            w_sat = r_acc[47:16];
        end else if (r_acc[ACC_W-1]) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = 32'sh7FFF_FFFF;
        end
    end

    assign o_res_push          = w_emit;
    assign o_res.result_value  = w_sat;
    assign o_res.result_index  = 6'(r_row);
    assign o_res.last          = (r_row == w_nm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_n        <= NCNT_W'(ORDER_RESET);
            r_mcnt     <= '0;
            r_vcnt     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            if (w_lmat && r_mcnt < MCNT_W'(DEPTH)) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
            if (w_lvec && r_vcnt < NCNT_W'(MAX_N)) begin
                r_vcnt <= r_vcnt + 1'b1;
            end
            if (w_start) begin
                r_n   <= w_n;
                r_row <= '0;
                r_col <= '0;
            end
            if (w_issue && !w_issue_last) begin
                r_col <= r_col + 1'b1;
            end
            if (r_s2_valid) begin
                r_acc <= r_acc + ACC_W'(r_p);
            end
            if (w_emit) begin
                r_acc <= '0;
                if (r_row == w_nm1) begin
                    // run done: next loads start a new matrix and vector
                    r_mcnt <= '0;
                    r_vcnt <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    r_col <= i_cfg.lower_triangle ? '0 : r_row + 1'b1;
                end
            end
        end
    end

    // data path: memory read, then multiply
    always_ff @(posedge i_clk) begin
        if (w_lmat && r_mcnt < MCNT_W'(DEPTH)) begin
            r_pmem[r_mcnt[ADDR_W-1:0]] <= i_cmd.value;
        end
        r_t <= r_pmem[w_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_lvec && r_vcnt < NCNT_W'(MAX_N)) begin
            r_vmem[r_vcnt[IDX_W-1:0]] <= i_cmd.value;
        end
        r_x <= r_vmem[r_col];
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= w_issue_last;
        r_s1_unit <= i_cfg.unit_diagonal && (r_col == r_row);
        r_s2_last <= r_s1_last;
        if (r_s1_unit) begin
            r_p <= {{16{r_x[31]}}, r_x, 16'h0000};
        end else begin
            r_p <= r_t * r_x;
        end
    end
endmodule

>>> src/ptm_outq.sv
// Result queue between the engine and the output port.
module ptm_outq
    import ptm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);
    localparam int PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

    t_result          r_mem [RESQ_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(RESQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(RESQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(RESQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_res;
        end
    end
endmodule

>>> src/packed_triangular_matvec.sv
// Top level: packed triangular matrix times vector, y = T * x, Q16.16.
// Loads are taken while the engine is idle. A start runs, per row, one multiply-accumulate
// per column, then drains the pipeline and emits the row's result word; the emit waits
// while the result queue is full.
// Reset (synchronous, active low) empties both queues, clears load counts and
// restores the registers; the matrix and vector memories are not cleared.
module packed_triangular_matvec
    import ptm_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item side
    input  logic                  push,
    input  t_item                 i_item,
    output logic                  full,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    t_cfg    r_cfg;
    t_qctl   w_cmd_ctl;
    t_item   w_cmd;
    t_result w_res;
    logic    w_take, w_res_push, w_res_full;
    t_reg    w_reg;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    // register file; writes land on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_triangle    <= 1'b0;
            r_cfg.transposed_layout <= 1'b0;
            r_cfg.unit_diagonal     <= 1'b0;
            r_cfg.order             <= 7'(ORDER_RESET);
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_LOWER: r_cfg.lower_triangle    <= pwdata[0];
                REG_TRANS: r_cfg.transposed_layout <= pwdata[0];
                REG_UNIT:  r_cfg.unit_diagonal     <= pwdata[0];
                default:   r_cfg.order             <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_LOWER: prdata = {31'd0, r_cfg.lower_triangle};
            REG_TRANS: prdata = {31'd0, r_cfg.transposed_layout};
            REG_UNIT:  prdata = {31'd0, r_cfg.unit_diagonal};
            default:   prdata = {25'd0, r_cfg.order};
        endcase
    end

    // accept and queue commands
    ptm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (w_take),
        .o_ctl   (w_cmd_ctl),
        .o_cmd   (w_cmd)
    );

    // store loads, run the row sums
    ptm_engine #(.MAX_N(MAX_N)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_ctl  (w_cmd_ctl),
        .i_cmd      (w_cmd),
        .o_cmd_take (w_take),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    // hold finished words until popped
    ptm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (o_result)
    );
endmodule

>>> src/ptm_checker.sv
// Port-level checks for the packed triangular matrix-vector block.
module ptm_checker
    import ptm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result,
    input logic    pready
);
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result queue not empty after reset");

    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !full) else $error("item queue full after reset");

    a_pready: assert property (@(posedge i_clk)
        pready) else $error("pready dropped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting word changed");
endmodule

bind packed_triangular_matvec ptm_checker u_ptm_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for the packed triangular matrix-vector block.
module tb_top;
    import ptm_pkg::*;

    localparam int N_MAX      = MAX_N_DEF;
    localparam int PACK_SLOTS = N_MAX * (N_MAX + 1) / 2;
    localparam int SETTLE     = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    t_item                 i_item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    packed_triangular_matvec u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the block's registers and memories
    t_cfg               cfg_mirror;
    logic signed [31:0] tri_mem [PACK_SLOTS];
    logic signed [31:0] vec_mem [N_MAX];
    int                 tri_count;
    int                 vec_count;

    // Expected output words, oldest first; fresh_rows holds one start's rows
    t_result            rows_due[$];
    t_result            fresh_rows[$];

    int                 mismatches;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;

    // Directed table: typed expectation only on single-row starts
    typedef struct {
        t_op                op;
        logic signed [31:0] value;
        bit                 typed;
        logic signed [31:0] y;
    } t_row;

    t_row directed_rows [] = '{
        '{OP_LOAD_MAT, 32'sh0001_0000, 0, 0},
        '{OP_LOAD_VEC, 32'sh7FFF_FFFF, 0, 0},
        '{OP_START,    32'sh0000_0000, 1, 32'sh7FFF_FFFF},
        '{OP_LOAD_MAT, 32'sh8000_0000, 0, 0},
        '{OP_LOAD_VEC, 32'sh8000_0000, 0, 0},
        '{OP_START,    32'shFFFF_FFFF, 1, 32'sh7FFF_FFFF},
        '{OP_LOAD_MAT, 32'sh7FFF_FFFF, 0, 0},
        '{OP_LOAD_VEC, 32'sh8000_0000, 0, 0},
        '{OP_START,    32'sh1234_5678, 1, 32'sh8000_0000},
        '{OP_NONE,     32'shA5A5_A5A5, 0, 0},
        '{OP_LOAD_MAT, 32'shFFFF_FFFF, 0, 0},
        '{OP_LOAD_VEC, 32'sh0000_0001, 0, 0},
        '{OP_START,    32'sh0000_0000, 1, 32'shFFFF_FFFF},
        '{OP_LOAD_MAT, 32'sh0002_0000, 0, 0},
        '{OP_LOAD_VEC, 32'sh0003_0000, 0, 0},
        '{OP_NONE,     32'sh5A5A_5A5A, 0, 0},
        '{OP_START,    32'sh7FFF_FFFF, 1, 32'sh0006_0000},
        '{OP_LOAD_VEC, 32'shFFFF_8000, 0, 0},
        '{OP_LOAD_MAT, 32'sh0000_0000, 0, 0},
        '{OP_START,    32'sh0000_0000, 0, 0}
    };

    // Random phases: lower, transposed, unit diagonal, order
    t_cfg phase_cfgs [] = '{
        '{1'b0, 1'b0, 1'b0, 7'd8},
        '{1'b1, 1'b0, 1'b1, 7'd5},
        '{1'b0, 1'b1, 1'b1, 7'd0},
        '{1'b1, 1'b1, 1'b0, 7'd3},
        '{1'b0, 1'b0, 1'b1, 7'd2},
        '{1'b1, 1'b1, 1'b1, 7'd7}
    };

    // Clock, period 2
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int eff_order(logic [6:0] ord);
        if (ord == 0) return 1;
        if (ord > N_MAX) return N_MAX;
        return ord;
    endfunction

    // Slot of T[r][c] in the packed array for the current layout
    function automatic int slot_of(int r, int c, int n);
        if (!cfg_mirror.lower_triangle) begin
            if (!cfg_mirror.transposed_layout) return c * (c + 1) / 2 + r;
            return r * n - r * (r - 1) / 2 + (c - r);
        end
        if (!cfg_mirror.transposed_layout) return c * n - c * (c - 1) / 2 + (r - c);
        return r * (r + 1) / 2 + c;
    endfunction

    // One row of T*x: exact sum split into floored quotients and residues
    function automatic logic signed [31:0] row_dot(int r, int n);
        longint qsum;
        longint rsum;
        longint tv;
        longint xv;
        longint prod;
        longint q;
        longint total;
        int     lo;
        int     hi;
        qsum = 0;
        rsum = 0;
        lo = cfg_mirror.lower_triangle ? 0 : r;
        hi = cfg_mirror.lower_triangle ? r : n - 1;
        for (int c = lo; c <= hi; c++) begin
            xv = longint'(vec_mem[c]);
            if (c == r && cfg_mirror.unit_diagonal) begin
                qsum += xv;
            end else begin
                tv = longint'(tri_mem[slot_of(r, c, n)]);
                prod = tv * xv;
                q = prod >>> 16;
                qsum += q;
                rsum += prod - (q <<< 16);
            end
        end
        total = qsum + (rsum >>> 16);
        if (total > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (total < -64'sh8000_0000) return 32'sh8000_0000;
        return total[31:0];
    endfunction

    // Apply one accepted word; rows of a start go to fresh_rows
    task automatic apply_word(t_op op, logic signed [31:0] v);
        int      n;
        t_result res;
        case (op)
            OP_LOAD_MAT: begin
                if (tri_count < PACK_SLOTS) begin
                    tri_mem[tri_count] = v;
                    tri_count++;
                end
            end
            OP_LOAD_VEC: begin
                if (vec_count < N_MAX) begin
                    vec_mem[vec_count] = v;
                    vec_count++;
                end
            end
            OP_START: begin
                n = eff_order(cfg_mirror.order);
                for (int r = 0; r < n; r++) begin
                    res.result_value = row_dot(r, n);
                    res.result_index = r[5:0];
                    res.last         = (r == n - 1);
                    fresh_rows.push_back(res);
                end
                tri_count = 0;
                vec_count = 0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Offer one word; hold it until accepted, then predict
    task automatic send_word(t_op op, logic signed [31:0] v, bit typed = 0,
                             logic signed [31:0] y = 0);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{opcode: op, value: v};
        do @(posedge i_clk); while (full);
        apply_word(op, v);
        while (fresh_rows.size() > 0) begin
            res = fresh_rows.pop_front();
            if (typed) res.result_value = y;
            rows_due.push_back(res);
        end
        @(negedge i_clk);
    endtask

    // Drop push, wait for every expected word, then let the engine settle
    task automatic drain();
        push <= 1'b0;
        while (rows_due.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_LOWER: cfg_mirror.lower_triangle    = data[0];
            REG_TRANS: cfg_mirror.transposed_layout = data[0];
            REG_UNIT:  cfg_mirror.unit_diagonal     = data[0];
            REG_ORDER: cfg_mirror.order             = data[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_cfg(t_cfg c);
        write_reg(REG_LOWER, {31'd0, c.lower_triangle});
        write_reg(REG_TRANS, {31'd0, c.transposed_layout});
        write_reg(REG_UNIT,  {31'd0, c.unit_diagonal});
        write_reg(REG_ORDER, {25'd0, c.order});
    endtask

    // Mostly small Q16.16 values, some full-range, some extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            3: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0001_0000;
                    default: return 32'shFFFF_0000;
                endcase
            end
            default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    // Full matrix and vector in random interleave, then start
    task automatic send_full_set(int n);
        int left_mat;
        int left_vec;
        left_mat = n * (n + 1) / 2;
        left_vec = n;
        while (left_mat + left_vec > 0) begin
            if (left_vec == 0 || (left_mat > 0 && $urandom_range(left_mat + left_vec - 1)
                                                  < left_mat)) begin
                send_word(OP_LOAD_MAT, pick_value());
                left_mat--;
            end else begin
                send_word(OP_LOAD_VEC, pick_value());
                left_vec--;
            end
        end
        send_word(OP_START, $urandom);
    endtask

    // Partial or excess loads with stray words; every slot was written earlier
    task automatic send_broken_set(int n);
        int count;
        count = $urandom_range(n * (n + 1) / 2 + n + 4);
        repeat (count) begin
            case ($urandom_range(9))
                0:       send_word(OP_NONE, $urandom);
                1, 2, 3: send_word(OP_LOAD_VEC, pick_value());
                default: send_word(OP_LOAD_MAT, pick_value());
            endcase
        end
        send_word(OP_START, $urandom);
    endtask

    // Receiver: random pops, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each accepted output word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word index %0d value %h",
                                          o_result.result_index, o_result.result_value));
            end else begin
                want = rows_due.pop_front();
                if (o_result.result_value !== want.result_value)
                    report_mismatch($sformatf("row %0d value %h, want %h",
                                              want.result_index, o_result.result_value,
                                              want.result_value));
                if (o_result.result_index !== want.result_index)
                    report_mismatch($sformatf("index %0d, want %0d",
                                              o_result.result_index, want.result_index));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("row %0d last %b, want %b",
                                              want.result_index, o_result.last, want.last));
            end
        end
    end

    // Main sequence
    initial begin
        int n;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_item        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_cycles   = 0;
        mismatches    = 0;
        tri_count     = 0;
        vec_count     = 0;
        cfg_mirror    = '{1'b0, 1'b0, 1'b0, 7'(ORDER_RESET)};
        send_idle_pct = 35;
        recv_idle_pct = 52;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: one-by-one system hits saturation, floor and stray opcodes
        write_cfg('{1'b0, 1'b0, 1'b0, 7'd1});
        foreach (directed_rows[k])
            send_word(directed_rows[k].op, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].y);
        drain();

        // Unit diagonal at order 1: y is x itself
        write_reg(REG_UNIT, 32'd1);
        send_word(OP_LOAD_MAT, 32'sh7FFF_FFFF);
        send_word(OP_LOAD_VEC, 32'shDEAD_BEEF);
        send_word(OP_START, 32'sh0, 1, 32'shDEAD_BEEF);
        drain();

        // Random phases; the first set writes every slot later orders read
        foreach (phase_cfgs[p]) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_cfg(phase_cfgs[p]);
            n = eff_order(phase_cfgs[p].order);
            // Long receiver stall: fill the result and command queues
            if (p == 0) hold_cycles = 400;
            for (int s = 0; s < ((p == 0) ? 2 : 1); s++) begin
                if ((p == 0 && s == 0) || $urandom_range(9) < 7) send_full_set(n);
                else send_broken_set(n);
            end
            drain();
        end

        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
